>>> rtl/core/gtpl_pkg.sv
// Shared types and constants for the gliding three-pole low-pass core.
// No dependencies; the top level imports it.
package gtpl_pkg;

  // Cascade depth is fixed by the filter topology.
  localparam int NUM_POLES = 3;
  localparam int STEP_BITS = $clog2(NUM_POLES);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NUM_POLES - 1);

  // Configuration register map.
  localparam int CFG_INDEX_BITS = 2;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_COEFF_TARGET = 2'd0,
    REG_GLIDE_STEP   = 2'd1
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } gtpl_state_t;

endpackage

>>> rtl/core/gtpl_stream_if.sv
// Valid/ready stream interfaces for the sample input and the filtered output.
// Depends on nothing; widths come from the instantiating parameter.
interface gtpl_sample_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface gtpl_sample_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

>>> rtl/core/gliding_three_pole_lowpass_core.sv
// Sequencing: a request is accepted while idle, then each pole in turn takes a step
//   on the single shared multiply-shift-add unit before the core is idle again.
// Flow: no new request is taken while one is in work; the poles share one multiplier,
//   and a waiting result holds the last pole step until the output register frees.
// Reset (rst, synchronous, active high): poles clear to zero, coefficient
//   accumulator and target load full scale, glide step clears, output empties.
module gliding_three_pole_lowpass_core #(
  parameter int COEFF_BITS      = 12,
  parameter int SAMPLE_BITS     = 16,
  parameter int GLIDE_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  gtpl_sample_in_if.sink                      audio,
  gtpl_sample_out_if.source                   filtered,
  input  logic                                cfg_we,
  input  logic [gtpl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COEFF_BITS+GLIDE_FRAC_BITS-1:0] cfg_data
);

  import gtpl_pkg::*;

  localparam int ACC_BITS = COEFF_BITS + GLIDE_FRAC_BITS;

  // Sequencer
  gtpl_state_t            state;
  gtpl_state_t            state_next;
  logic [STEP_BITS-1:0]   step;
  logic                   last_step;
  logic                   out_free;
  logic                   advance;
  logic                   accept;

  // Pole state. The three poles rotate through s0..s2 so the shared unit always
  // works on s0; after three steps they are back in order.
  logic signed [SAMPLE_BITS-1:0] s0;
  logic signed [SAMPLE_BITS-1:0] s1;
  logic signed [SAMPLE_BITS-1:0] s2;
  logic signed [SAMPLE_BITS-1:0] operand;
  logic signed [SAMPLE_BITS-1:0] pole_out;

  // Coefficient glide
  logic [COEFF_BITS-1:0] coeff_target;
  logic [ACC_BITS-1:0]   glide_step;
  logic [ACC_BITS-1:0]   coeff_accum;
  logic [ACC_BITS-1:0]   coeff_accum_next;
  logic [ACC_BITS-1:0]   target_full;
  logic [ACC_BITS:0]     rise_sum;

  // Output register
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_data;

  assign audio.ready         = (state == ST_IDLE);
  assign filtered.valid      = out_valid;
  assign filtered.sample_out = out_data;

  assign accept    = audio.valid && audio.ready;
  assign last_step = (state == ST_RUN) && (step == LAST_STEP);
  assign out_free  = !out_valid || filtered.ready;
  // hold the final pole step while the previous result is still unclaimed
  assign advance   = (state == ST_RUN) && (!last_step || out_free);

  gtpl_pole_unit #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEFF_BITS  (COEFF_BITS)
  ) u_pole (
    .x      (operand),
    .h      (s0),
    .coeff  (coeff_accum[ACC_BITS-1:GLIDE_FRAC_BITS]),
    .h_next (pole_out)
  );

  // Glide: move the accumulator by one step toward the target, clamping
  // once it reaches or passes it; a zero step jumps straight there.
  always_comb begin
    target_full      = {coeff_target, {GLIDE_FRAC_BITS{1'b0}}};
    rise_sum         = {1'b0, coeff_accum} + {1'b0, glide_step};
    coeff_accum_next = coeff_accum;
    if (glide_step == '0) begin
      coeff_accum_next = target_full;
    end else if (coeff_accum < target_full) begin
      coeff_accum_next = (rise_sum >= {1'b0, target_full}) ? target_full
                                                           : rise_sum[ACC_BITS-1:0];
    end else if (coeff_accum > target_full) begin
      coeff_accum_next = ((coeff_accum - target_full) <= glide_step) ? target_full
                                                                     : coeff_accum - glide_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (audio.valid) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (last_step && out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= '0;
      s0           <= '0;
      s1           <= '0;
      s2           <= '0;
      out_valid    <= 1'b0;
      coeff_target <= '1;
      glide_step   <= '0;
      coeff_accum  <= {{COEFF_BITS{1'b1}}, {GLIDE_FRAC_BITS{1'b0}}};
    end else begin
      // configuration must be written only while idle; the core does not enforce this
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_COEFF_TARGET: coeff_target <= cfg_data[COEFF_BITS-1:0];
          REG_GLIDE_STEP:   glide_step   <= cfg_data;
          default: ;
        endcase
      end

      if (accept) begin
        step <= '0;
      end

      if (advance) begin
        // rotate poles; the fresh value feeds the next pole as its input
        s0   <= s1;
        s1   <= s2;
        s2   <= pole_out;
        step <= last_step ? '0 : step + 1'b1;
        if (last_step) begin
          coeff_accum <= coeff_accum_next;
        end
      end

      if (advance && last_step) begin
        out_valid <= 1'b1;
      end else if (filtered.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      operand <= audio.sample_in;
    end else if (advance) begin
      operand <= pole_out;
    end
    if (advance && last_step) begin
      out_data <= pole_out;
    end
  end

endmodule

>>> rtl/core/gtpl_pole_unit.sv
// Shared one-pole arithmetic: h + floor(c * (x - h) / 2^COEFF_BITS).
// Used once per cycle by the top level's sequencer while it runs and is not stalled; no package dependency.
module gtpl_pole_unit #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 12
) (
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] h,
  input  logic        [COEFF_BITS-1:0]  coeff,
  output logic signed [SAMPLE_BITS-1:0] h_next
);

  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + COEFF_BITS + 1;
  localparam int SUM_BITS  = SAMPLE_BITS + 2;

  logic signed [DIFF_BITS-1:0] diff;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] scaled;
  logic signed [SUM_BITS-1:0]  sum;

  always_comb begin
    diff   = DIFF_BITS'(x) - DIFF_BITS'(h);
    prod   = PROD_BITS'($signed({1'b0, coeff})) * PROD_BITS'(diff);
    // arithmetic shift gives the floor for negative products
    scaled = prod >>> COEFF_BITS;
    sum    = SUM_BITS'(h) + scaled[SUM_BITS-1:0];
    h_next = sum[SAMPLE_BITS-1:0];
  end

endmodule

>>> rtl/core/gtpl_checker.sv
// Port-level checks for the gliding three-pole low-pass core.
// Depends on the top level's ports only; attached by the bind below.
module gtpl_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_data
);

  // a request keeps the core busy for the following cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("core ready right after accepting a request");

  // with the output empty, the result stays absent through the pole steps and then shows
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |-> ##3 !out_valid ##1 out_valid)
    else $error("result timing off after request");

  // a new result only appears while a request is being worked on
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no request in flight");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

endmodule

bind gliding_three_pole_lowpass_core gtpl_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_gtpl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (audio.valid),
  .in_ready  (audio.ready),
  .out_valid (filtered.valid),
  .out_ready (filtered.ready),
  .out_data  (filtered.sample_out)
);
